### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OFB_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OFB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/ofb_pkg.sv
// Package: geometry defaults, operation and status codes, link bytes, stage record.
package ofb_pkg;

  localparam int DEF_COLUMNS = 128;
  localparam int DEF_ROWS    = 64;
  localparam int DEF_PAGES   = 8;

  localparam int STORE_BYTES = 1024;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam logic [2:0] OP_WRITE_PIXEL = 3'd0;
  localparam logic [2:0] OP_FILL        = 3'd1;
  localparam logic [2:0] OP_START       = 3'd2;
  localparam logic [2:0] OP_NEXT_BYTE   = 3'd3;
  localparam logic [2:0] OP_COMPLETE    = 3'd4;
  localparam logic [2:0] OP_LINK_ERROR  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_NO_BYTE = 2'd3;

  localparam logic [7:0] CMD_LEN       = 8'd4;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] DATA_CTRL     = 8'h40;

  // Result and store-access plan of one transaction, decided at accept.
  typedef struct packed {
    logic [1:0]        status;
    logic              byte_valid;
    logic [7:0]        tx_byte;
    logic              first;
    logic              last;
    logic              done;
    logic              from_mem;
    logic              pix_we;
    logic              color;
    logic [7:0]        mask;
    logic [ADDR_W-1:0] addr;
  } pre_t;

endpackage

### rtl/ofb_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
module ofb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ofb_ctrl.sv
// Flush sequencer: phase, page and byte counters, address and result planning.
module ofb_ctrl import ofb_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  parameter int PAGES   = DEF_PAGES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [2:0] operation_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic       color_i,
  output pre_t       pre_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD_SEND,
    PH_CMD_WAIT,
    PH_DATA_SEND,
    PH_DATA_WAIT
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] page_q, page_d;
  logic [7:0] idx_q, idx_d;

  logic [10:0] pix_addr, data_addr;
  logic [4:0]  page_inc;
  pre_t        pre;

  assign pix_addr  = 11'(x_i) + 11'(y_i[5:3]) * 11'(COLUMNS);
  assign data_addr = 11'(page_q[2:0]) * 11'(COLUMNS) + 11'(idx_q) - 11'd1;
  assign page_inc  = 5'(page_q) + 5'd1;

  always_comb begin
    phase_d        = phase_q;
    page_d         = page_q;
    idx_d          = idx_q;
    pre            = '0;
    pre.status     = ST_OK;
    pre.color      = color_i;
    unique case (operation_i)
      OP_WRITE_PIXEL: begin
        if ({1'b0, x_i} >= 9'(COLUMNS) || {1'b0, y_i} >= 9'(ROWS)) begin
          pre.status = ST_RANGE;
        end else begin
          pre.pix_we = 1'b1;
          pre.addr   = pix_addr[ADDR_W-1:0];
          pre.mask   = 8'(8'd1 << y_i[2:0]);
        end
      end
      OP_START: begin
        if (phase_q != PH_IDLE) begin
          pre.status = ST_BUSY;
        end else begin
          page_d  = '0;
          idx_d   = '0;
          phase_d = PH_CMD_SEND;
        end
      end
      OP_NEXT_BYTE: begin
        if (phase_q == PH_CMD_SEND) begin
          pre.byte_valid = 1'b1;
          pre.first      = (idx_q == 8'd0);
          case (idx_q[1:0])
            2'd0:    pre.tx_byte = CMD_COL_LO;
            2'd1:    pre.tx_byte = 8'(CMD_PAGE_BASE + 8'(page_q));
            2'd2:    pre.tx_byte = CMD_COL_LO;
            default: pre.tx_byte = CMD_COL_HI;
          endcase
          if (idx_q + 8'd1 >= CMD_LEN) begin
            pre.last = 1'b1;
            phase_d  = PH_CMD_WAIT;
            idx_d    = '0;
          end else begin
            idx_d = idx_q + 8'd1;
          end
        end else if (phase_q == PH_DATA_SEND) begin
          pre.byte_valid = 1'b1;
          if (idx_q == 8'd0) begin
            pre.tx_byte = DATA_CTRL;
            pre.first   = 1'b1;
          end else begin
            pre.from_mem = 1'b1;
            pre.addr     = data_addr[ADDR_W-1:0];
          end
          if ({1'b0, idx_q} >= 9'(COLUMNS)) begin
            pre.last = 1'b1;
            phase_d  = PH_DATA_WAIT;
            idx_d    = '0;
          end else begin
            idx_d = idx_q + 8'd1;
          end
        end else begin
          pre.status = ST_NO_BYTE;
        end
      end
      OP_COMPLETE: begin
        if (phase_q == PH_CMD_WAIT) begin
          phase_d = PH_DATA_SEND;
          idx_d   = '0;
        end else if (phase_q == PH_DATA_WAIT) begin
          idx_d  = '0;
          page_d = page_inc[3:0];
          if (page_inc < 5'(PAGES)) begin
            phase_d = PH_CMD_SEND;
          end else begin
            phase_d  = PH_IDLE;
            pre.done = 1'b1;
          end
        end
      end
      OP_LINK_ERROR: begin
        phase_d = PH_IDLE;
        idx_d   = '0;
      end
      default: begin
      end
    endcase
  end

  assign pre_o = pre;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      page_q  <= '0;
      idx_q   <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      page_q  <= page_d;
      idx_q   <= idx_d;
    end
  end

endmodule

### rtl/oled_framebuffer_page_flush_unit.sv
// Top level: page-organised framebuffer with page-by-page link flush.
// Usage notes. Every operation is one input transaction and yields exactly one
// result transaction. The frame store is a 1024-byte single-port-write RAM with
// a registered read; each transaction reads it in its accept cycle and, for a
// pixel write, writes the modified byte back when it leaves stage s1, with
// forwarding so that a back-to-back access to the same byte sees the new value.
// Pixel writes, byte requests and all other short operations are accepted at
// one per cycle while the output is not stalled, and the result passes through
// the s1 register and then the output register. A fill sweeps the whole store
// one byte per cycle, and the input is stalled until the sweep ends. After
// reset the same sweep clears the store, so the input stays stalled until it
// ends. Page bytes are read from the store when requested.
`include "assert_macros.svh"

module oled_framebuffer_page_flush_unit import ofb_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  parameter int PAGES   = DEF_PAGES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic       color_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic       byte_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       first_of_transfer_o,
  output logic       last_of_transfer_o,
  output logic       update_done_o
);

  // Handshake and stage control.
  logic in_acc;
  logic s1_adv;
  logic s1_valid_q;
  pre_t s1_pre_q;
  pre_t pre;

  // Forwarding of the write-back that coincided with this stage's read.
  logic       fwd_hit_q;
  logic [7:0] fwd_data_q;

  // Fill / reset clearing sweep.
  logic              sweep_q;
  logic              sweep_val_q;
  logic [ADDR_W-1:0] sweep_cnt_q;

  // Store ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [7:0]        mem_byte;
  logic              s1_we;
  logic [7:0]        s1_wdata;

  // Output register.
  logic       out_valid_q;
  logic [1:0] out_status_q;
  logic       out_bv_q;
  logic [7:0] out_tx_q;
  logic       out_first_q;
  logic       out_last_q;
  logic       out_done_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = sweep_q || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  ofb_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .PAGES   (PAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .operation_i (operation_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .color_i     (color_i),
    .pre_o       (pre)
  );

  // Byte as seen by this transaction: RAM data, or the write-back that landed
  // in the same cycle as the read.
  assign mem_byte = fwd_hit_q ? fwd_data_q : ram_rdata;

  assign s1_we    = s1_adv && s1_pre_q.pix_we;
  assign s1_wdata = s1_pre_q.color ? (mem_byte | s1_pre_q.mask)
                                   : (mem_byte & ~s1_pre_q.mask);

  // The sweep owns the write port; no pixel write-back is in flight then.
  assign ram_we    = sweep_q || s1_we;
  assign ram_waddr = sweep_q ? sweep_cnt_q : s1_pre_q.addr;
  assign ram_wdata = sweep_q ? {8{sweep_val_q}} : s1_wdata;

  ofb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (pre.addr),
    .rdata_o (ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
      sweep_q     <= 1'b1;
      sweep_val_q <= 1'b0;
      sweep_cnt_q <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= s1_we && (s1_pre_q.addr == pre.addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc && operation_i == OP_FILL) begin
        sweep_q     <= 1'b1;
        sweep_val_q <= color_i;
        sweep_cnt_q <= '0;
      end else if (sweep_q) begin
        sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
        if (sweep_cnt_q == ADDR_W'(STORE_BYTES - 1)) begin
          sweep_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pre_q   <= pre;
      fwd_data_q <= s1_wdata;
    end
    if (s1_adv) begin
      out_status_q <= s1_pre_q.status;
      out_bv_q     <= s1_pre_q.byte_valid;
      out_tx_q     <= s1_pre_q.from_mem ? mem_byte : s1_pre_q.tx_byte;
      out_first_q  <= s1_pre_q.first;
      out_last_q   <= s1_pre_q.last;
      out_done_q   <= s1_pre_q.done;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign byte_valid_o        = out_bv_q;
  assign tx_byte_o           = out_tx_q;
  assign first_of_transfer_o = out_first_q;
  assign last_of_transfer_o  = out_last_q;
  assign update_done_o       = out_done_q;

  // A pixel write-back never competes with the sweep for the write port.
  `OFB_ASSERT_IMPL(a_sweep_no_rmw, clk_i, rst_ni, sweep_q, !s1_we)
  // An accepted fill starts a sweep from the first byte.
  `OFB_ASSERT_NEXT(a_fill_sweeps, clk_i, rst_ni, in_acc && operation_i == OP_FILL,
                   sweep_q && sweep_cnt_q == '0)
  // A link byte always comes with ok status and never ends an update.
  `OFB_ASSERT_IMPL(a_byte_ok, clk_i, rst_ni, out_valid_o && byte_valid_o,
                   status_o == ST_OK && !update_done_o)

endmodule
